// ===== rtl/hvce_pkg.sv =====
// hvce_pkg: shared types and constants of the heightmap voxel column extractor
// no dependencies; imported by heightmap_voxel_column_extract and tb
`default_nettype none

package hvce_pkg;

    localparam int MAX_TILE_WIDTH = 4096;
    localparam int COL_W          = $clog2(MAX_TILE_WIDTH);
    localparam int CNT_W          = COL_W + 1;
    localparam int ROW_W          = 16;
    localparam int HGT_W          = 17;

    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;

    // register indexes, decoded from paddr[3:2]
    localparam logic [1:0] REG_TILE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_TILE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_LOWEST_POINT = 2'd2;

    localparam logic [12:0] TILE_WIDTH_RST  = 13'd1201;
    localparam logic [15:0] TILE_HEIGHT_RST = 16'd1201;

    typedef struct packed {
        logic                    last;
        logic [HGT_W-1:0]        voxel_count;
        logic signed [HGT_W-1:0] z_bottom;
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/heightmap_voxel_column_extract.sv =====
// heightmap_voxel_column_extract: top level, row stores, neighbor minimum and result queue
// depends on hvce_pkg
`default_nettype none

// Takes one height sample per cycle in raster order and emits voxel run descriptors.
// A sample is accepted in any cycle while the result queue holds four or fewer entries;
// each sample reads the two row stores (one 34-bit {older,newer} memory at the column,
// one 17-bit copy of the newer row at the next column) and is finished in the next cycle,
// when the write-back and up to two results enter an 8-entry queue. Results leave at one
// per cycle while the receiver is ready, so the sustained rate is one sample per cycle
// while most samples yield at most one run; samples that yield two runs are bounded by the
// output port. Row store contents are undefined after reset; no clearing pass is made.
module heightmap_voxel_column_extract (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // slave stream, tdata: height_sample[15:0]; tuser: tile_start
    input  wire logic                          i_s_axis_tvalid,
    output      logic                          o_s_axis_tready,
    input  wire logic [15:0]                   i_s_axis_tdata,
    input  wire logic                          i_s_axis_tuser,
    // master stream, tdata: col_index[11:0], row_index[27:12], z_bottom[44:28],
    // voxel_count[61:45], zero fill[63:62]; tlast: last_of_item
    output      logic                          o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output      logic [63:0]                   o_m_axis_tdata,
    output      logic                          o_m_axis_tlast,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hvce_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [hvce_pkg::DATA_W-1:0]   pwdata,
    output      logic [hvce_pkg::DATA_W-1:0]   prdata,
    output      logic                          pready
);
    import hvce_pkg::*;

    localparam logic [CNT_W-1:0] W_MAX = CNT_W'(MAX_TILE_WIDTH);
    localparam logic [CNT_W-1:0] W_MIN = CNT_W'(3);
    localparam logic [ROW_W-1:0] H_MIN = ROW_W'(3);

    // configuration registers
    logic [12:0]       r_tile_width;
    logic [15:0]       r_tile_height;
    logic [15:0]       r_lowest_point;

    // position counters
    logic [CNT_W-1:0]  r_col_cnt;
    logic [ROW_W-1:0]  r_row_cnt;

    // row stores
    logic [2*HGT_W-1:0] mem_a [MAX_TILE_WIDTH];
    logic [HGT_W-1:0]   mem_b [MAX_TILE_WIDTH];
    logic [2*HGT_W-1:0] r_rd_a;
    logic [HGT_W-1:0]   r_rd_b;

    // second stage
    logic                    r_s1_valid;
    logic [COL_W-1:0]        r_s1_col;
    logic [ROW_W-1:0]        r_s1_row;
    logic signed [HGT_W-1:0] r_s1_corr;
    logic                    r_s1_int;
    logic                    r_s1_bord;
    logic                    r_s1_rzero;
    logic                    r_fwd_a;
    logic                    r_fwd_b;
    logic signed [HGT_W-1:0] r_fwd_old;
    logic signed [HGT_W-1:0] r_fwd_new;
    logic signed [HGT_W-1:0] r_left;

    // result queue
    t_result           r_fifo [8];
    logic [2:0]        r_wr_ptr;
    logic [2:0]        r_rd_ptr;
    logic [3:0]        r_count;

    logic              cfg_wr;
    logic              in_acc;
    logic              out_acc;

    logic [CNT_W-1:0]  w_use;
    logic [ROW_W-1:0]  h_use;
    logic [CNT_W-1:0]  col_base;
    logic [ROW_W:0]    row_base;
    logic [CNT_W-1:0]  col_pos;
    logic [ROW_W:0]    row_pos;
    logic [COL_W-1:0]  s0_col;
    logic [COL_W-1:0]  s0_col_nxt;
    logic [ROW_W-1:0]  s0_row;
    logic              s0_int;
    logic              s0_bord;
    logic              s0_rzero;
    logic signed [HGT_W-1:0] s0_corr;
    logic [CNT_W-1:0]  n_col_cnt;

    logic signed [HGT_W-1:0] s1_up;
    logic signed [HGT_W-1:0] s1_mid;
    logic signed [HGT_W-1:0] s1_right;
    logic signed [HGT_W-1:0] min_a;
    logic signed [HGT_W-1:0] min_b;
    logic signed [HGT_W-1:0] s1_min;
    logic [HGT_W:0]          s1_span;
    t_result                 res_int;
    t_result                 res_bord;
    logic [1:0]              n_push;
    logic [2:0]              wr_ptr_b;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign in_acc  = i_s_axis_tvalid & o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid & i_m_axis_tready;

    // a new transaction is taken only if the queue can absorb two items in flight
    assign o_s_axis_tready = (r_count <= 4'd4);

    always_comb begin
        unique case (paddr[3:2])
            REG_TILE_WIDTH:   prdata = {19'd0, r_tile_width};
            REG_TILE_HEIGHT:  prdata = {16'd0, r_tile_height};
            REG_LOWEST_POINT: prdata = {{16{r_lowest_point[15]}}, r_lowest_point};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_width   <= TILE_WIDTH_RST;
            r_tile_height  <= TILE_HEIGHT_RST;
            r_lowest_point <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_TILE_WIDTH:   r_tile_width   <= pwdata[12:0];
                REG_TILE_HEIGHT:  r_tile_height  <= pwdata[15:0];
                REG_LOWEST_POINT: r_lowest_point <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // position of the incoming sample
    always_comb begin
        w_use = r_tile_width;
        if (w_use > W_MAX) w_use = W_MAX;
        if (w_use < W_MIN) w_use = W_MIN;
        h_use = (r_tile_height < H_MIN) ? H_MIN : r_tile_height;

        col_base = i_s_axis_tuser ? '0 : r_col_cnt;
        row_base = i_s_axis_tuser ? '0 : {1'b0, r_row_cnt};
        if (col_base >= w_use) begin
            col_pos = '0;
            row_pos = row_base + 1'b1;
        end else begin
            col_pos = col_base;
            row_pos = row_base;
        end
        if (row_pos >= {1'b0, h_use}) row_pos = '0;

        s0_col     = col_pos[COL_W-1:0];
        s0_col_nxt = s0_col + 1'b1;
        s0_row     = row_pos[ROW_W-1:0];
        n_col_cnt  = col_pos + 1'b1;
        s0_int     = (s0_row >= ROW_W'(2)) && (s0_col != '0) && (n_col_cnt < w_use);
        s0_bord    = (s0_row == '0) || (s0_col == '0) ||
                     ({1'b0, s0_row} + 1'b1 == {1'b0, h_use}) || (n_col_cnt == w_use);
        s0_rzero   = (n_col_cnt == W_MAX);
        s0_corr    = $signed({i_s_axis_tdata[15], i_s_axis_tdata})
                   - $signed({r_lowest_point[15], r_lowest_point});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (in_acc) begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= s0_row;
        end
    end

    // row store {older, newer}, read at the column
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            mem_a[r_s1_col] <= {s1_mid, r_s1_corr};
        end
        if (in_acc) begin
            r_rd_a <= mem_a[s0_col];
        end
    end

    // copy of the newer row, read one column ahead
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            mem_b[r_s1_col] <= r_s1_corr;
        end
        if (in_acc) begin
            r_rd_b <= mem_b[s0_col_nxt];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_left     <= '0;
        end else begin
            r_s1_valid <= in_acc;
            if (r_s1_valid) r_left <= s1_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_col   <= s0_col;
            r_s1_row   <= s0_row;
            r_s1_corr  <= s0_corr;
            r_s1_int   <= s0_int;
            r_s1_bord  <= s0_bord;
            r_s1_rzero <= s0_rzero;
            // the entry written this cycle is not yet visible to the read
            r_fwd_a    <= r_s1_valid && (r_s1_col == s0_col);
            r_fwd_b    <= r_s1_valid && (r_s1_col == s0_col_nxt);
            r_fwd_old  <= s1_mid;
            r_fwd_new  <= r_s1_corr;
        end
    end

    // neighbor minimum and run formation
    always_comb begin
        s1_up    = r_fwd_a ? r_fwd_old : $signed(r_rd_a[2*HGT_W-1:HGT_W]);
        s1_mid   = r_fwd_a ? r_fwd_new : $signed(r_rd_a[HGT_W-1:0]);
        if (r_s1_rzero)   s1_right = '0;
        else if (r_fwd_b) s1_right = r_fwd_new;
        else              s1_right = $signed(r_rd_b);

        min_a   = (s1_up < r_s1_corr) ? s1_up : r_s1_corr;
        min_b   = (r_left < s1_right) ? r_left : s1_right;
        s1_min  = (min_a < min_b) ? min_a : min_b;
        s1_span = $signed({s1_mid[HGT_W-1], s1_mid}) - $signed({s1_min[HGT_W-1], s1_min})
                + 1'b1;

        res_int.col  = r_s1_col;
        res_int.row  = r_s1_row - 1'b1;
        res_int.last = !r_s1_bord;
        if (s1_mid > s1_min) begin
            res_int.z_bottom    = s1_min;
            res_int.voxel_count = s1_span[HGT_W-1:0];
        end else begin
            res_int.z_bottom    = s1_mid;
            res_int.voxel_count = HGT_W'(1);
        end

        res_bord.col         = r_s1_col;
        res_bord.row         = r_s1_row;
        res_bord.z_bottom    = '0;
        res_bord.voxel_count = (r_s1_corr > 0) ? r_s1_corr : '0;
        res_bord.last        = 1'b1;

        n_push   = r_s1_valid ? ({1'b0, r_s1_int} + {1'b0, r_s1_bord}) : 2'd0;
        wr_ptr_b = r_wr_ptr + {2'b00, r_s1_int};
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && r_s1_int)  r_fifo[r_wr_ptr] <= res_int;
        if (r_s1_valid && r_s1_bord) r_fifo[wr_ptr_b] <= res_bord;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + {1'b0, n_push};
            if (out_acc) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count  <= r_count + {2'b00, n_push} - {3'b000, out_acc};
        end
    end

    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = {2'b00, r_fifo[r_rd_ptr].voxel_count, r_fifo[r_rd_ptr].z_bottom,
                              r_fifo[r_rd_ptr].row, r_fifo[r_rd_ptr].col};
    assign o_m_axis_tlast  = r_fifo[r_rd_ptr].last;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// tb: self-checking bench for heightmap_voxel_column_extract, raster streams with random stalls
// depends on hvce_pkg and the rtl top level; each run descriptor is checked against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hvce_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE       = 16;
    localparam int N_OPENING    = 22;

    typedef logic signed [HGT_W-1:0] t_hgt;

    typedef struct packed {
        logic [COL_W-1:0]        col;
        logic [ROW_W-1:0]        row;
        logic signed [HGT_W-1:0] z_bottom;
        logic [HGT_W-1:0]        count;
        logic                    last;
    } t_voxel_run;

    typedef struct packed {
        logic [15:0] height;
        logic        start;
        logic        typed;
        logic        reconf;
        t_voxel_run  golden;
    } t_opening_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic        pready;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [63:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;

    // predictor state
    t_hgt              older_row [MAX_TILE_WIDTH];
    t_hgt              newer_row [MAX_TILE_WIDTH];
    t_hgt              left_cell = '0;
    int                col_pos = 0;
    int                row_pos = 0;
    logic [12:0]       cfg_width = TILE_WIDTH_RST;
    logic [15:0]       cfg_height = TILE_HEIGHT_RST;
    logic signed [15:0] cfg_lowest = '0;

    t_voxel_run   runs_due [$];
    t_voxel_run   typed_run = '0;
    logic         typed_on = 1'b0;
    logic         calm = 1'b0;
    int           mismatches = 0;
    int           cycles = 0;
    t_opening_row opening_rows [N_OPENING];

    always #4 i_clk = ~i_clk;

    heightmap_voxel_column_extract DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // adds one expected run at the tail of the queue
    function automatic void append_run(input t_voxel_run run);
        runs_due = {runs_due, run};
    endfunction

    // moves the raster position by one sample and queues the runs it completes
    function automatic int advance_raster(input logic signed [15:0] height, input logic start);
        int w;
        int h;
        int c;
        int r;
        int corr;
        int up;
        int mid;
        int right;
        int mn;
        int n;
        w = int'(cfg_width);
        h = int'(cfg_height);
        n = 0;
        if (w > MAX_TILE_WIDTH) w = MAX_TILE_WIDTH;
        if (w < 3) w = 3;
        if (h < 3) h = 3;
        if (start) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        r = row_pos;
        corr = int'(height) - int'(cfg_lowest);
        up = int'(older_row[c]);
        mid = int'(newer_row[c]);
        right = (c + 1 < MAX_TILE_WIDTH) ? int'(newer_row[c + 1]) : 0;

        // the cell above is finished once its lower neighbor arrives
        if (r >= 2 && c >= 1 && c + 1 < w) begin
            mn = up;
            if (corr < mn) mn = corr;
            if (int'(left_cell) < mn) mn = int'(left_cell);
            if (right < mn) mn = right;
            if (mid > mn)
                append_run(t_voxel_run'{12'(c), 16'(r - 1), 17'(mn),
                                        17'(mid - mn + 1), 1'b0});
            else
                append_run(t_voxel_run'{12'(c), 16'(r - 1), 17'(mid), 17'd1, 1'b0});
            n++;
        end
        if (r == 0 || c == 0 || r + 1 == h || c + 1 == w) begin
            append_run(t_voxel_run'{12'(c), 16'(r), 17'd0,
                                    17'(corr > 0 ? corr : 0), 1'b0});
            n++;
        end
        if (n > 0) runs_due[runs_due.size() - 1].last = 1'b1;

        older_row[c] = t_hgt'(mid);
        newer_row[c] = t_hgt'(corr);
        left_cell = t_hgt'(mid);
        col_pos = c + 1;
        return n;
    endfunction

    task automatic note_mismatch(input string what, input t_voxel_run want,
                                 input t_voxel_run got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): expected col %0d row %0d z %0d count %0d last %0d, ",
                     what, want.col, want.row, want.z_bottom, want.count, want.last,
                     "got col %0d row %0d z %0d count %0d last %0d",
                     got.col, got.row, got.z_bottom, got.count, got.last);
    endtask

    // input transactions feed the predictor, output transactions are checked in order
    always @(posedge i_clk) begin
        t_voxel_run got;
        t_voxel_run want;
        int n;
        if (i_rst_n) begin
            if (s_tvalid && o_s_axis_tready) begin
                n = advance_raster(s_tdata, s_tuser);
                if (typed_on) begin
                    repeat (n) void'(runs_due.pop_back());
                    append_run(typed_run);
                end
            end
            if (o_m_axis_tvalid && m_tready) begin
                got = t_voxel_run'{o_m_axis_tdata[11:0], o_m_axis_tdata[27:12],
                                   o_m_axis_tdata[44:28], o_m_axis_tdata[61:45],
                                   o_m_axis_tlast};
                if (runs_due.size() == 0) begin
                    note_mismatch("unexpected", '0, got);
                end else begin
                    want = runs_due.pop_front();
                    if (got != want) note_mismatch("wrong field", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == LIMIT_CYCLES) begin
            $display("tb failed");
            $finish;
        end
    end

    // receiver side: random stall bursts between ready stretches
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 6) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
            end else begin
                m_tready = 1'b1;
                repeat ($urandom_range(0, 15)) @(negedge i_clk);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_sample(input logic [15:0] height, input logic start);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata = height;
        s_tuser = start;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
        typed_on = 1'b0;
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (runs_due.size() != 0) @(negedge i_clk);
        // samples that yield no run may still be in flight
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_TILE_WIDTH:   cfg_width = value[12:0];
            REG_TILE_HEIGHT:  cfg_height = value[15:0];
            REG_LOWEST_POINT: cfg_lowest = value[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic configure(input logic [12:0] w, input logic [15:0] h,
                             input logic [15:0] lowest);
        wait_idle();
        write_reg(REG_TILE_WIDTH, 32'(w));
        write_reg(REG_TILE_HEIGHT, 32'(h));
        write_reg(REG_LOWEST_POINT, 32'(lowest));
    endtask

    function automatic logic [15:0] pick_height(input logic [15:0] base);
        case ($urandom_range(0, 9))
            0:       return 16'($urandom);
            1:       return 16'h7fff;
            2:       return 16'h8000;
            default: return base + 16'($urandom_range(0, 24)) - 16'd12;
        endcase
    endfunction

    task automatic run_phase(input int count, input int restart_pct, input logic [15:0] base,
                             input logic fresh);
        logic start;
        for (int i = 0; i < count; i++) begin
            start = (i == 0 && fresh) || ($urandom_range(0, 99) < restart_pct);
            send_sample(pick_height(base), start);
        end
    endtask

    initial begin
        logic [15:0] base;
        opening_rows = '{
            // reset settings: first row cells are all border runs
            '{16'h7fff, 1'b1, 1'b1, 1'b0, '{12'd0, 16'd0, 17'sd0, 17'd32767, 1'b1}},
            '{16'h8000, 1'b0, 1'b1, 1'b0, '{12'd1, 16'd0, 17'sd0, 17'd0, 1'b1}},
            '{16'h0000, 1'b0, 1'b1, 1'b0, '{12'd2, 16'd0, 17'sd0, 17'd0, 1'b1}},
            '{16'h0001, 1'b0, 1'b1, 1'b0, '{12'd3, 16'd0, 17'sd0, 17'd1, 1'b1}},
            // smallest tile, high center cell
            '{16'h7fff, 1'b1, 1'b0, 1'b1, '0},
            '{16'h8000, 1'b0, 1'b0, 1'b0, '0},
            '{16'h0000, 1'b0, 1'b0, 1'b0, '0},
            '{16'h0000, 1'b0, 1'b0, 1'b0, '0},
            '{16'h7fff, 1'b0, 1'b0, 1'b0, '0},
            '{16'h0000, 1'b0, 1'b0, 1'b0, '0},
            '{16'h000a, 1'b0, 1'b0, 1'b0, '0},
            '{16'h8000, 1'b0, 1'b0, 1'b0, '0},
            '{16'h000a, 1'b0, 1'b0, 1'b0, '0},
            // wraps past the last row, low center cell
            '{16'h0064, 1'b0, 1'b0, 1'b0, '0},
            '{16'h0064, 1'b0, 1'b0, 1'b0, '0},
            '{16'h0064, 1'b0, 1'b0, 1'b0, '0},
            '{16'h0064, 1'b0, 1'b0, 1'b0, '0},
            '{16'h8000, 1'b0, 1'b0, 1'b0, '0},
            '{16'h0064, 1'b0, 1'b0, 1'b0, '0},
            '{16'h0064, 1'b0, 1'b0, 1'b0, '0},
            '{16'h0064, 1'b0, 1'b0, 1'b0, '0},
            '{16'h0064, 1'b0, 1'b0, 1'b0, '0}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int i = 0; i < N_OPENING; i++) begin
            // width and height below three clamp to three
            if (opening_rows[i].reconf) configure(13'd2, 16'd0, 16'h8000);
            typed_on = opening_rows[i].typed;
            typed_run = opening_rows[i].golden;
            send_sample(opening_rows[i].height, opening_rows[i].start);
        end

        base = 16'($urandom);
        configure(13'h1fff, 16'hffff, 16'h7fff);
        run_phase(12, 0, base, 1'b1);

        base = 16'($urandom);
        configure(13'd4096, 16'd3, 16'h8000);
        run_phase(12, 0, base, 1'b1);

        base = 16'($urandom);
        configure(13'd3, 16'hffff, base - 16'($urandom_range(0, 30)));
        run_phase(60, 0, base, 1'b1);

        base = 16'($urandom);
        configure(13'($urandom_range(3, 10)), 16'($urandom_range(3, 8)), 16'($urandom));
        run_phase(80, 5, base, 1'b1);

        // narrowing the width mid-tile sends the position to the next row
        base = 16'($urandom);
        configure(13'd8, 16'd40, base - 16'd5);
        run_phase(30, 0, base, 1'b1);
        wait_idle();
        write_reg(REG_TILE_WIDTH, 32'd5);
        run_phase(30, 0, base, 1'b0);

        base = 16'($urandom);
        configure(13'd0, 16'd1, base + 16'($urandom_range(0, 10)));
        run_phase(50, 3, base, 1'b1);

        base = 16'($urandom);
        configure(13'($urandom_range(3, 16)), 16'($urandom_range(3, 12)), 16'd0);
        run_phase(80, 3, base, 1'b1);

        base = 16'($urandom);
        calm = 1'b1;
        configure(13'($urandom_range(3, 10)), 16'($urandom_range(3, 10)),
                  base - 16'($urandom_range(0, 20)));
        run_phase(80, 0, base, 1'b1);

        s_tvalid = 1'b0;
        while (runs_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (mismatches == 0 && runs_due.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
